/* rtl/slpb_pkg.sv */
// shared types, constants and register map of the status led priority blinker
package slpb_pkg;

    // default width of the millisecond counter
    localparam int TIME_BITS_DEF = 32;

    // configuration register reset values
    localparam logic [15:0] BOOT_FLASH_RST  = 16'd500;
    localparam logic [15:0] RESET_FLASH_RST = 16'd1000;
    localparam logic [31:0] NET_ERROR_RST   = 32'd600000;

    // configuration port
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;
    localparam logic [1:0] REG_BOOT_FLASH  = 2'd0;
    localparam logic [1:0] REG_RESET_FLASH = 2'd1;
    localparam logic [1:0] REG_NET_ERROR   = 2'd2;

    // operation codes
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_SET_SETUP   = 3'd1;
    localparam logic [2:0] OP_SET_LINK    = 3'd2;
    localparam logic [2:0] OP_SET_SENSOR  = 3'd3;
    localparam logic [2:0] OP_SET_FATAL   = 3'd4;
    localparam logic [2:0] OP_RESET_FLASH = 3'd5;

    // link states
    localparam logic [1:0] LINK_DOWN       = 2'd0;
    localparam logic [1:0] LINK_CONNECTING = 2'd1;
    localparam logic [1:0] LINK_UP         = 2'd2;

    // blink periods and lit times in milliseconds
    localparam int SETUP_PERIOD  = 2000;
    localparam int SETUP_ON      = 1000;
    localparam int FAST_PERIOD   = 200;
    localparam int FAST_ON       = 100;
    localparam int LINK_PERIOD   = 500;
    localparam int LINK_ON       = 250;
    localparam int SENSOR_PERIOD = 5000;
    localparam int SENSOR_ON     = 100;

    localparam int SETUP_PH_BITS  = $clog2(SETUP_PERIOD);
    localparam int FAST_PH_BITS   = $clog2(FAST_PERIOD);
    localparam int LINK_PH_BITS   = $clog2(LINK_PERIOD);
    localparam int SENSOR_PH_BITS = $clog2(SENSOR_PERIOD);

    // colours as red, green, blue bytes
    localparam logic [23:0] COLOUR_OFF    = 24'h000000;
    localparam logic [23:0] COLOUR_RED    = 24'hFF0000;
    localparam logic [23:0] COLOUR_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] COLOUR_BLUE   = 24'h0000FF;
    localparam logic [23:0] COLOUR_YELLOW = 24'hFFC800;
    localparam logic [23:0] COLOUR_ORANGE = 24'hFF5000;

    // input item
    typedef struct packed {
        logic [2:0] operation;
        logic       flag_value;
        logic [1:0] link_state_in;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       changed;
    } out_item_t;

    // configuration values and boot flash restart strobe
    typedef struct packed {
        logic [15:0] boot_flash_ms;
        logic [15:0] reset_flash_ms;
        logic [31:0] net_error_after_ms;
        logic        boot_restart;
    } cfg_t;

endpackage

/* rtl/slpb_core.sv */
// state registers and colour priority logic of the status led priority blinker
module slpb_core #(
    parameter int TIME_BITS = slpb_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  slpb_pkg::in_item_t   in_item,
    input  slpb_pkg::cfg_t       cfg,
    output slpb_pkg::out_item_t  result
);

    localparam int SPB = slpb_pkg::SETUP_PH_BITS;
    localparam int FPB = slpb_pkg::FAST_PH_BITS;
    localparam int LPB = slpb_pkg::LINK_PH_BITS;
    localparam int OPB = slpb_pkg::SENSOR_PH_BITS;

    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [SPB-1:0]       ph_setup_reg, ph_setup_next;
    logic [FPB-1:0]       ph_fast_reg, ph_fast_next;
    logic [LPB-1:0]       ph_link_reg, ph_link_next;
    logic [OPB-1:0]       ph_sensor_reg, ph_sensor_next;
    logic                 setup_reg, setup_next;
    logic [1:0]           link_reg, link_next;
    logic [TIME_BITS-1:0] down_since_reg, down_since_next;
    logic                 sensor_reg, sensor_next;
    logic                 fatal_reg, fatal_next;
    logic [TIME_BITS-1:0] rf_until_reg, rf_until_next;
    logic                 rf_live_reg, rf_live_next;
    logic [TIME_BITS-1:0] bf_until_reg, bf_until_next;
    logic                 bf_live_reg, bf_live_next;
    logic                 latch_reg, latch_next;
    logic [23:0]          last_colour_reg, colour_next;

    // deadline reached when now - deadline is not negative
    function automatic logic reached(input logic [TIME_BITS-1:0] now,
                                     input logic [TIME_BITS-1:0] deadline);
        logic [TIME_BITS-1:0] diff;
        diff = now - deadline;
        return !diff[TIME_BITS-1];
    endfunction

    // effect of the item, then colour pick on the updated state
    always_comb
    begin
        logic tick;
        logic wrap;
        logic [TIME_BITS-1:0] net_deadline;

        tick            = (in_item.operation == slpb_pkg::OP_TICK);
        time_next       = tick ? time_reg + TIME_BITS'(1) : time_reg;
        wrap            = tick && (time_next == '0);
        setup_next      = setup_reg;
        link_next       = link_reg;
        down_since_next = down_since_reg;
        sensor_next     = sensor_reg;
        fatal_next      = fatal_reg;
        rf_until_next   = rf_until_reg;
        rf_live_next    = rf_live_reg;
        bf_until_next   = bf_until_reg;
        bf_live_next    = bf_live_reg;
        latch_next      = latch_reg;

        // blink phases follow time_ms modulo each period, restarting on counter wrap
        if (wrap)
        begin
            ph_setup_next  = '0;
            ph_fast_next   = '0;
            ph_link_next   = '0;
            ph_sensor_next = '0;
        end
        else if (tick)
        begin
            ph_setup_next  = (ph_setup_reg == SPB'(slpb_pkg::SETUP_PERIOD - 1)) ?
                             '0 : ph_setup_reg + SPB'(1);
            ph_fast_next   = (ph_fast_reg == FPB'(slpb_pkg::FAST_PERIOD - 1)) ?
                             '0 : ph_fast_reg + FPB'(1);
            ph_link_next   = (ph_link_reg == LPB'(slpb_pkg::LINK_PERIOD - 1)) ?
                             '0 : ph_link_reg + LPB'(1);
            ph_sensor_next = (ph_sensor_reg == OPB'(slpb_pkg::SENSOR_PERIOD - 1)) ?
                             '0 : ph_sensor_reg + OPB'(1);
        end
        else
        begin
            ph_setup_next  = ph_setup_reg;
            ph_fast_next   = ph_fast_reg;
            ph_link_next   = ph_link_reg;
            ph_sensor_next = ph_sensor_reg;
        end

        // event decode
        unique case (in_item.operation)
            slpb_pkg::OP_TICK:
            begin
            end
            slpb_pkg::OP_SET_SETUP:
                setup_next = in_item.flag_value;
            slpb_pkg::OP_SET_LINK:
            begin
                if (in_item.link_state_in == slpb_pkg::LINK_DOWN)
                begin
                    if (link_reg != slpb_pkg::LINK_DOWN)
                    begin
                        down_since_next = time_reg;
                        latch_next      = 1'b0;
                    end
                    link_next = in_item.link_state_in;
                end
                else if (in_item.link_state_in == slpb_pkg::LINK_CONNECTING ||
                         in_item.link_state_in == slpb_pkg::LINK_UP)
                begin
                    latch_next = 1'b0;
                    link_next  = in_item.link_state_in;
                end
            end
            slpb_pkg::OP_SET_SENSOR:
                sensor_next = in_item.flag_value;
            slpb_pkg::OP_SET_FATAL:
                fatal_next = in_item.flag_value;
            slpb_pkg::OP_RESET_FLASH:
            begin
                rf_until_next = time_reg + TIME_BITS'(cfg.reset_flash_ms);
                rf_live_next  = 1'b1;
            end
            default:
            begin
            end
        endcase

        // priority pick; finished flashes drop their live bit
        net_deadline = down_since_next + TIME_BITS'(cfg.net_error_after_ms);
        colour_next  = slpb_pkg::COLOUR_OFF;
        if (rf_live_next && !reached(time_next, rf_until_next))
        begin
            colour_next = slpb_pkg::COLOUR_RED;
        end
        else
        begin
            rf_live_next = 1'b0;
            if (bf_live_next && !reached(time_next, bf_until_next))
            begin
                colour_next = slpb_pkg::COLOUR_WHITE;
            end
            else
            begin
                bf_live_next = 1'b0;
                if (link_next == slpb_pkg::LINK_DOWN && !latch_next &&
                    reached(time_next, net_deadline))
                    latch_next = 1'b1;
                if (setup_next)
                begin
                    if (ph_setup_next < SPB'(slpb_pkg::SETUP_ON))
                        colour_next = slpb_pkg::COLOUR_BLUE;
                end
                else if (fatal_next || (link_next == slpb_pkg::LINK_DOWN && latch_next))
                begin
                    if (ph_fast_next < FPB'(slpb_pkg::FAST_ON))
                        colour_next = slpb_pkg::COLOUR_RED;
                end
                else if (link_next != slpb_pkg::LINK_UP)
                begin
                    if (ph_link_next < LPB'(slpb_pkg::LINK_ON))
                        colour_next = slpb_pkg::COLOUR_YELLOW;
                end
                else if (sensor_next)
                begin
                    if (ph_sensor_next < OPB'(slpb_pkg::SENSOR_ON))
                        colour_next = slpb_pkg::COLOUR_ORANGE;
                end
            end
        end
    end

    // result item
    assign result.red     = colour_next[23:16];
    assign result.green   = colour_next[15:8];
    assign result.blue    = colour_next[7:0];
    assign result.changed = (colour_next != last_colour_reg);

    // state update on item acceptance and boot flash restart on register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg        <= '0;
            ph_setup_reg    <= '0;
            ph_fast_reg     <= '0;
            ph_link_reg     <= '0;
            ph_sensor_reg   <= '0;
            setup_reg       <= 1'b0;
            link_reg        <= slpb_pkg::LINK_DOWN;
            down_since_reg  <= '0;
            sensor_reg      <= 1'b0;
            fatal_reg       <= 1'b0;
            rf_until_reg    <= '0;
            rf_live_reg     <= 1'b0;
            bf_until_reg    <= TIME_BITS'(slpb_pkg::BOOT_FLASH_RST);
            bf_live_reg     <= 1'b1;
            latch_reg       <= 1'b0;
            last_colour_reg <= slpb_pkg::COLOUR_OFF;
        end
        else
        begin
            if (accept)
            begin
                time_reg        <= time_next;
                ph_setup_reg    <= ph_setup_next;
                ph_fast_reg     <= ph_fast_next;
                ph_link_reg     <= ph_link_next;
                ph_sensor_reg   <= ph_sensor_next;
                setup_reg       <= setup_next;
                link_reg        <= link_next;
                down_since_reg  <= down_since_next;
                sensor_reg      <= sensor_next;
                fatal_reg       <= fatal_next;
                rf_until_reg    <= rf_until_next;
                rf_live_reg     <= rf_live_next;
                bf_until_reg    <= bf_until_next;
                bf_live_reg     <= bf_live_next;
                latch_reg       <= latch_next;
                last_colour_reg <= colour_next;
            end
            if (cfg.boot_restart)
            begin
                bf_until_reg <= time_reg + TIME_BITS'(cfg.boot_flash_ms);
                bf_live_reg  <= 1'b1;
            end
        end
    end

endmodule

/* rtl/slpb_out_buf.sv */
// two-entry output buffer with skid stage for result items
module slpb_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  slpb_pkg::out_item_t  push_item,
    output logic                 push_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output slpb_pkg::out_item_t  out_item
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    slpb_pkg::out_item_t out_reg, out_next;
    slpb_pkg::out_item_t skid_reg, skid_next;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_reg;

    // output slot refills from skid first, a stalled push parks in skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = push_item;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_item;
            skid_valid_next = 1'b1;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/status_led_priority_blinker.sv */
// Status LED priority blinker: each accepted result is registered in the output buffer;
// one item per cycle while in_ready is high. The colour logic sits between the
// state registers and a two-entry output buffer, so input stays ready while one
// result waits. Register reads and writes complete in the APB access cycle,
// pready always high. Reset (rst_n low, asynchronous) clears time and flags,
// sets the link down, loads default registers and starts the white boot flash.
module status_led_priority_blinker #(
    parameter int TIME_BITS = slpb_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  slpb_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output slpb_pkg::out_item_t             out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slpb_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [slpb_pkg::DATA_BITS-1:0]  pwdata,
    output logic [slpb_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready
);

    logic [15:0]         boot_ms_reg;
    logic [15:0]         reset_ms_reg;
    logic [31:0]         net_err_reg;
    logic                wr_en;
    logic [1:0]          reg_idx;
    logic                accept;
    slpb_pkg::cfg_t      cfg;
    slpb_pkg::out_item_t result;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[slpb_pkg::ADDR_BITS-1:2];
    assign accept  = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_ms_reg  <= slpb_pkg::BOOT_FLASH_RST;
            reset_ms_reg <= slpb_pkg::RESET_FLASH_RST;
            net_err_reg  <= slpb_pkg::NET_ERROR_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                slpb_pkg::REG_BOOT_FLASH:  boot_ms_reg  <= pwdata[15:0];
                slpb_pkg::REG_RESET_FLASH: reset_ms_reg <= pwdata[15:0];
                slpb_pkg::REG_NET_ERROR:   net_err_reg  <= pwdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            slpb_pkg::REG_BOOT_FLASH:  prdata = {16'd0, boot_ms_reg};
            slpb_pkg::REG_RESET_FLASH: prdata = {16'd0, reset_ms_reg};
            slpb_pkg::REG_NET_ERROR:   prdata = net_err_reg;
            default:                   prdata = '0;
        endcase
    end

    // settings seen by the core; the boot flash restart takes the length being written
    assign cfg.boot_flash_ms      = pwdata[15:0];
    assign cfg.reset_flash_ms     = reset_ms_reg;
    assign cfg.net_error_after_ms = net_err_reg;
    assign cfg.boot_restart       = wr_en && (reg_idx == slpb_pkg::REG_BOOT_FLASH);

    slpb_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .cfg     (cfg),
        .result  (result)
    );

    slpb_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_item  (result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
